// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for the concurrent checks in the RTL. Each one samples on the
// rising edge of clk and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ===== sv/tdcwsd_pkg.sv =====
// ----------------------------------------------------------------------------
// TDC word stream decoder package
// Types and constants shared by the decoder modules.
// ----------------------------------------------------------------------------
package tdcwsd_pkg;

    localparam int WORD_W   = 32;
    localparam int CHAN_W   = 19;
    localparam int AMP_W    = 16;
    localparam int DELTA_W  = 3;
    localparam int HIT_W    = 16;
    localparam int MOD_W    = 9;
    localparam int EVT_W    = 24;
    localparam int CFG_W    = 24;
    localparam int CH_W     = 5;
    localparam int ID_W     = 4;
    localparam int MAP_W    = 6;

    // Word type codes taken from the top byte.
    localparam logic [3:0] HIT_NIBBLE    = 4'h4;
    localparam logic [3:0] MODULE_NIBBLE = 4'h8;
    localparam logic [7:0] EVENT_HEADER  = 8'hA0;

    localparam logic signed [MOD_W-1:0] MODULE_NONE = -9'sd1;
    localparam logic signed [MOD_W-1:0] MODULE_MAX  = 9'sd255;

    // Configuration register indexes.
    localparam logic CFG_REMAP_ENABLE = 1'b0;
    localparam logic CFG_EVENT_LIMIT  = 1'b1;

    typedef enum logic [1:0] {
        KIND_HIT    = 2'd0,
        KIND_MODULE = 2'd1,
        KIND_EVENT  = 2'd2,
        KIND_STOP   = 2'd3
    } word_kind_t;

    typedef struct packed {
        logic                       bad_tdc_flag;
        logic [EVT_W-1:0]           event_index;
        logic signed [MOD_W-1:0]    module_index;
        logic [HIT_W-1:0]           hit_index;
        logic [DELTA_W-1:0]         delta;
        logic [AMP_W-1:0]           amplitude;
        logic signed [CHAN_W-1:0]   channel;
    } result_t;

endpackage

// ===== sv/tdc_word_stream_decoder.sv =====
// A word taken goes into the input register and then, once the output register
// has room, on to the output register, where m_tvalid shows any result it gives.
// Throughput: one word per clock unless m_tready stalls the output; the input and
// output registers are separate stages: a new word is taken while a result waits.
// Reset (rst_n low, asynchronous) empties both stages, sets remap_enable to 1,
// event_limit to 0, the module index to -1 and the hit and event counts to 0.
// ----------------------------------------------------------------------------
// TDC word stream decoder
// Decodes 32-bit TDC readout words into hit, module header, event header and
// stop results. The decoder tracks the current module index, the number of hits
// in the current event and the number of events, and halts for good once an
// event header arrives after the configured nonzero event limit has been reached.
// ----------------------------------------------------------------------------
module tdc_word_stream_decoder
    import tdcwsd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    // Configuration write port, index 0 remap_enable, index 1 event_limit.
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,

    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [31:0]        s_tdata,   // [31:0] data_word

    output logic               m_tvalid,
    input  logic               m_tready,
    // [18:0] channel, [34:19] amplitude, [37:35] delta, [53:38] hit_index,
    // [62:54] module_index, [86:63] event_index, [87] bad_tdc_flag
    output logic [87:0]        m_tdata,
    output logic [1:0]         m_tuser    // [1:0] word_kind
);

    // Configuration registers.
    logic               remap_enable_reg;
    logic [EVT_W-1:0]   event_limit_reg;

    // Input stage.
    logic               in_valid_reg;
    logic [WORD_W-1:0]  in_data_reg;

    // Decoder state.
    logic signed [MOD_W-1:0] module_count_reg, module_count_next;
    logic [HIT_W-1:0]        hit_count_reg, hit_count_next;
    logic [EVT_W-1:0]        event_count_reg, event_count_next;
    logic                    stopped_reg, stopped_next;

    // Output stage.
    logic               out_valid_reg;
    word_kind_t         out_kind_reg;
    result_t            out_data_reg;

    logic               out_room;
    logic               advance;
    logic [7:0]         b3;
    logic               is_hit;
    logic               is_module;
    logic               is_event;
    logic               limit_hit;
    logic               res_valid;
    word_kind_t         res_kind;
    result_t            res;
    logic signed [CHAN_W-1:0] hit_channel;
    logic               hit_bad;

    // The output register frees up when it is empty or being taken this cycle.
    // A word in the input stage moves on only then, even if it gives no result.
    assign out_room = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_room;
    assign s_tready = !in_valid_reg || out_room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remap_enable_reg <= 1'b1;
            event_limit_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_REMAP_ENABLE: remap_enable_reg <= cfg_data[0];
                CFG_EVENT_LIMIT:  event_limit_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg <= s_tdata;
        end
    end

    // Word classification from the top byte.
    assign b3        = in_data_reg[31:24];
    assign is_hit    = (b3[7:4] == HIT_NIBBLE);
    assign is_module = (b3[7:4] == MODULE_NIBBLE);
    assign is_event  = (b3 == EVENT_HEADER);
    assign limit_hit = (event_limit_reg != '0) && (event_count_reg >= event_limit_reg);

    tdcwsd_chan_calc u_chan_calc (
        .remap_enable (remap_enable_reg),
        .ch           (in_data_reg[23:19]),
        .tdc_id       (in_data_reg[27:24]),
        .module_idx   (module_count_reg),
        .channel      (hit_channel),
        .bad_tdc      (hit_bad)
    );

    // Result and next state for the word in the input stage. Once stopped, every
    // word is dropped and the state is frozen.
    always_comb
    begin
        module_count_next = module_count_reg;
        hit_count_next    = hit_count_reg;
        event_count_next  = event_count_reg;
        stopped_next      = stopped_reg;
        res_valid         = 1'b0;
        res_kind          = KIND_HIT;
        res               = '0;
        res.hit_index     = hit_count_reg;
        res.module_index  = module_count_reg;

        if (!stopped_reg)
        begin
            if (is_hit)
            begin
                res_valid        = 1'b1;
                res_kind         = KIND_HIT;
                res.channel      = hit_channel;
                res.amplitude    = in_data_reg[15:0];
                res.delta        = in_data_reg[18:16];
                res.bad_tdc_flag = hit_bad;
                hit_count_next   = hit_count_reg + HIT_W'(1);
            end
            else if (is_module)
            begin
                res_valid = 1'b1;
                res_kind  = KIND_MODULE;
                if (module_count_reg != MODULE_MAX)
                begin
                    module_count_next = module_count_reg + 9'sd1;
                end
                res.module_index = module_count_next;
            end
            else if (is_event)
            begin
                res_valid       = 1'b1;
                res.event_index = event_count_reg;
                if (limit_hit)
                begin
                    // The stop result reports the state as it stands.
                    res_kind     = KIND_STOP;
                    stopped_next = 1'b1;
                end
                else
                begin
                    res_kind          = KIND_EVENT;
                    module_count_next = MODULE_NONE;
                    hit_count_next    = '0;
                    event_count_next  = event_count_reg + EVT_W'(1);
                    res.hit_index     = '0;
                    res.module_index  = MODULE_NONE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            module_count_reg <= MODULE_NONE;
            hit_count_reg    <= '0;
            event_count_reg  <= '0;
            stopped_reg      <= 1'b0;
        end
        else if (advance)
        begin
            module_count_reg <= module_count_next;
            hit_count_reg    <= hit_count_next;
            event_count_reg  <= event_count_next;
            stopped_reg      <= stopped_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= res_valid;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            out_kind_reg <= res_kind;
            out_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = out_data_reg;

    // ------------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------------
`include "assert_macros.svh"

    // After the stop nothing new may reach the output.
    `ASSERT_NEXT(a_no_result_after_stop, stopped_reg && !m_tvalid, !m_tvalid)

    // A stop result can only leave once the decoder has halted.
    `ASSERT_IMPLIES(a_stop_sets_halt, m_tvalid && (m_tuser == KIND_STOP), stopped_reg)

    // A word waiting behind a stalled result stays in the input stage.
    `ASSERT_NEXT(a_input_holds, in_valid_reg && m_tvalid && !m_tready,
                 in_valid_reg && $stable(in_data_reg))

    // An accepted event header restarts the module index and the hit count.
    `ASSERT_NEXT(a_event_restart, advance && !stopped_reg && is_event && !limit_hit,
                 (hit_count_reg == '0) && (module_count_reg == MODULE_NONE))

endmodule

// ===== sv/tdcwsd_chan_calc.sv =====
// ----------------------------------------------------------------------------
// TDC channel calculator
// Turns the channel and tdc id fields of a hit word into a global channel
// number, either through the detector remapping or as a raw offset number.
// ----------------------------------------------------------------------------
module tdcwsd_chan_calc
    import tdcwsd_pkg::*;
(
    input  logic                      remap_enable,
    input  logic [CH_W-1:0]           ch,
    input  logic [ID_W-1:0]           tdc_id,
    input  logic signed [MOD_W-1:0]   module_idx,
    output logic signed [CHAN_W-1:0]  channel,
    output logic                      bad_tdc
);

    logic [1:0]               tdc_num;
    logic                     id_ok;
    logic [3:0]               k;
    logic [MAP_W-1:0]         map;
    logic signed [CHAN_W-1:0] mod_x64;
    logic signed [CHAN_W-1:0] mod_x512;
    logic signed [CHAN_W-1:0] remap_chan;
    logic signed [CHAN_W-1:0] raw_chan;

    always_comb
    begin
        id_ok   = 1'b1;
        tdc_num = 2'd0;
        case (tdc_id)
            4'd1:    tdc_num = 2'd0;
            4'd2:    tdc_num = 2'd1;
            4'd4:    tdc_num = 2'd2;
            4'd8:    tdc_num = 2'd3;
            default: id_ok   = 1'b0;
        endcase
    end

    // The map terms never overlap: 32*n[1] + 16*(1 - k[1]) + 8*n[0] + (7 - {k[3:2], k[0]}),
    // and the last term is the bitwise inverse of a three-bit value.
    assign k   = ch[CH_W-1:1];
    assign map = id_ok ? {tdc_num[1], ~k[1], tdc_num[0], ~k[3], ~k[2], ~k[0]} : '0;

    assign mod_x64  = {{4{module_idx[MOD_W-1]}}, module_idx, 6'b0};
    assign mod_x512 = {module_idx[MOD_W-1], module_idx, 9'b0};

    assign remap_chan = mod_x64 + $signed({13'b0, map});
    assign raw_chan   = 19'sd100 + mod_x512 + $signed({14'b0, ch})
                        + $signed({10'b0, tdc_id, 5'b0});

    assign channel = remap_enable ? remap_chan : raw_chan;
    assign bad_tdc = remap_enable && !id_ok;

endmodule
